FILE: rtl/prac_pkg.sv
package prac_pkg;

    localparam int DEF_SINE_TABLE_ENTRIES = 1024;
    localparam int DEF_TRIG_FRAC_BITS     = 15;

    localparam int COORD_W  = 32;
    localparam int ANGLE_W  = 16;
    localparam int OFFSET_W = 13;

    localparam int TURN_UNITS    = 23040;
    localparam int QUARTER_UNITS = 5760;
    // a quarter turn is 2^7 * 45 units
    localparam int QUARTER_SHIFT = 7;
    localparam int QUARTER_ODD   = 45;

    localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

    // sine of a Q31 angle by a thirteen-term series, every product truncated
    function automatic logic [63:0] sine_q31(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = x;
        term = x;
        term = ((term * x) >> 31) / 64'd2;
        term = ((term * x) >> 31) / 64'd3;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x) >> 31) / 64'd4;
        term = ((term * x) >> 31) / 64'd5;
        sum  = sum + term;
        term = ((term * x) >> 31) / 64'd6;
        term = ((term * x) >> 31) / 64'd7;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x) >> 31) / 64'd8;
        term = ((term * x) >> 31) / 64'd9;
        sum  = sum + term;
        term = ((term * x) >> 31) / 64'd10;
        term = ((term * x) >> 31) / 64'd11;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x) >> 31) / 64'd12;
        term = ((term * x) >> 31) / 64'd13;
        sum  = sum + term;
        term = ((term * x) >> 31) / 64'd14;
        term = ((term * x) >> 31) / 64'd15;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x) >> 31) / 64'd16;
        term = ((term * x) >> 31) / 64'd17;
        sum  = sum + term;
        term = ((term * x) >> 31) / 64'd18;
        term = ((term * x) >> 31) / 64'd19;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x) >> 31) / 64'd20;
        term = ((term * x) >> 31) / 64'd21;
        sum  = sum + term;
        term = ((term * x) >> 31) / 64'd22;
        term = ((term * x) >> 31) / 64'd23;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = ((term * x) >> 31) / 64'd24;
        term = ((term * x) >> 31) / 64'd25;
        sum  = sum + term;
        return sum;
    endfunction

endpackage

FILE: rtl/point_rotation_about_center_top.sv
// Rotates a Q16.16 point counter-clockwise about a pivot by an angle in 1/64 degree,
// taken modulo 360 degrees; results are rounded to nearest (ties up) and saturated.
// One point is accepted every cycle while result_stall stays low; a result reaches the
// outputs once it has passed the pipeline: input register, two stages of angle-to-index
// scaling, the registered dual-read sine table, the four products, the rounded sums and
// the saturating output register. A stall on the result side holds the pipeline and
// reaches point_stall once the stages ahead of it are full. No setup is needed after
// reset.
module point_rotation_about_center_top
    import prac_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = DEF_SINE_TABLE_ENTRIES,
    parameter int TRIG_FRAC_BITS     = DEF_TRIG_FRAC_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      point_valid,
    output logic                      point_stall,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] pivot_x,
    input  logic signed [COORD_W-1:0] pivot_y,
    input  logic signed [ANGLE_W-1:0] angle_sixtyfourths,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic signed [COORD_W-1:0] rotated_x,
    output logic signed [COORD_W-1:0] rotated_y
);

    localparam int F        = TRIG_FRAC_BITS;
    localparam int IDX_W    = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int ANG_W    = ANGLE_W + 1;
    localparam int RED_W    = 15;
    localparam int M_W      = IDX_W + OFFSET_W;
    localparam int V_W      = M_W - QUARTER_SHIFT;
    localparam int RECIP_SH = V_W + 6;
    localparam int RECIP_W  = RECIP_SH - 4;
    localparam int RPROD_W  = V_W + RECIP_W;
    localparam int D_W      = COORD_W + 1;
    localparam int TRIG_W   = F + 2;
    localparam int PROD_W   = D_W + TRIG_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int RND_W    = SUM_W - F;
    localparam int TOT_W    = RND_W + 1;

    localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SH) + 64'(QUARTER_ODD - 1))
                                         / 64'(QUARTER_ODD);
    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_FULL[RECIP_W-1:0];

    localparam logic signed [ANG_W-1:0] TURN_S = ANG_W'(TURN_UNITS);
    localparam logic [RED_W-1:0] Q1_U = RED_W'(QUARTER_UNITS);
    localparam logic [RED_W-1:0] Q2_U = RED_W'(2 * QUARTER_UNITS);
    localparam logic [RED_W-1:0] Q3_U = RED_W'(3 * QUARTER_UNITS);
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (F - 1));

    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_FOURTH = 2'd3
    } quadrant_t;

    // stage enables, the pipeline closes up bubbles
    logic en1, en2, en3, en4, en5, en6, en7;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;

    // stage 1: reduced angle and deltas
    logic signed [ANG_W-1:0] ang_ext;
    logic signed [ANG_W-1:0] wrap_once;
    logic signed [ANG_W-1:0] wrap_full;
    logic [RED_W-1:0]        reduced;
    logic [RED_W-1:0]        offset_wide;
    quadrant_t               s1_quad_next;
    logic [OFFSET_W-1:0]     s1_offset_next;
    logic signed [D_W-1:0]   s1_dx_next;
    logic signed [D_W-1:0]   s1_dy_next;

    quadrant_t                 s1_quad_reg, s2_quad_reg, s3_quad_reg, s4_quad_reg;
    logic [OFFSET_W-1:0]       s1_offset_reg;
    logic signed [D_W-1:0]     s1_dx_reg, s2_dx_reg, s3_dx_reg, s4_dx_reg;
    logic signed [D_W-1:0]     s1_dy_reg, s2_dy_reg, s3_dy_reg, s4_dy_reg;
    logic signed [COORD_W-1:0] s1_cx_reg, s2_cx_reg, s3_cx_reg, s4_cx_reg, s5_cx_reg, s6_cx_reg;
    logic signed [COORD_W-1:0] s1_cy_reg, s2_cy_reg, s3_cy_reg, s4_cy_reg, s5_cy_reg, s6_cy_reg;

    // stages 2 and 3: offset to table index, /5760 as >>7 then reciprocal of 45
    logic [M_W-1:0]     s2_scaled_next;
    logic [V_W-1:0]     s2_scaled_reg;
    logic [RPROD_W-1:0] s3_prod_next;
    logic [IDX_W-1:0]   s3_idx_reg;
    logic [IDX_W-1:0]   cos_addr;

    // stage 4: table outputs
    logic [F:0] sin_value;
    logic [F:0] cos_value;

    // stage 5: products
    logic signed [TRIG_W-1:0] sin_pos, cos_pos;
    logic signed [TRIG_W-1:0] sn_next, cs_next;
    logic signed [PROD_W-1:0] s5_xc_next, s5_ys_next, s5_xs_next, s5_yc_next;
    logic signed [PROD_W-1:0] s5_xc_reg, s5_ys_reg, s5_xs_reg, s5_yc_reg;

    // stage 6: rounded rotated deltas
    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic signed [SUM_W-1:0] rsum_x, rsum_y;
    logic signed [RND_W-1:0] s6_rx_reg, s6_ry_reg;

    // stage 7: pivot added and saturated
    logic signed [TOT_W-1:0]   tot_x, tot_y;
    logic [COORD_W-1:0]        s7_x_next, s7_y_next;
    logic signed [COORD_W-1:0] s7_x_reg, s7_y_reg;

    assign en7 = !s7_valid_reg || !result_stall;
    assign en6 = !s6_valid_reg || en7;
    assign en5 = !s5_valid_reg || en6;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign point_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= point_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                s4_valid_reg <= s3_valid_reg;
            if (en5)
                s5_valid_reg <= s4_valid_reg;
            if (en6)
                s6_valid_reg <= s5_valid_reg;
            if (en7)
                s7_valid_reg <= s6_valid_reg;
        end
    end

    // angle modulo a full turn, then quadrant and offset
    always_comb
    begin
        ang_ext   = ANG_W'(angle_sixtyfourths);
        wrap_once = ang_ext[ANG_W-1] ? ang_ext + TURN_S : ang_ext;
        if (wrap_once[ANG_W-1])
            wrap_full = wrap_once + TURN_S;
        else if (wrap_once >= TURN_S)
            wrap_full = wrap_once - TURN_S;
        else
            wrap_full = wrap_once;
        reduced = wrap_full[RED_W-1:0];

        if (reduced < Q1_U)
        begin
            s1_quad_next = QUAD_FIRST;
            offset_wide  = reduced;
        end
        else if (reduced < Q2_U)
        begin
            s1_quad_next = QUAD_SECOND;
            offset_wide  = reduced - Q1_U;
        end
        else if (reduced < Q3_U)
        begin
            s1_quad_next = QUAD_THIRD;
            offset_wide  = reduced - Q2_U;
        end
        else
        begin
            s1_quad_next = QUAD_FOURTH;
            offset_wide  = reduced - Q3_U;
        end
        s1_offset_next = offset_wide[OFFSET_W-1:0];

        s1_dx_next = D_W'(point_x) - D_W'(pivot_x);
        s1_dy_next = D_W'(point_y) - D_W'(pivot_y);
    end

    assign s2_scaled_next = M_W'(s1_offset_reg) * M_W'(SINE_TABLE_ENTRIES)
                            + M_W'(QUARTER_UNITS / 2);
    assign s3_prod_next   = RPROD_W'(s2_scaled_reg) * RPROD_W'(RECIP_K);
    assign cos_addr       = IDX_W'(SINE_TABLE_ENTRIES) - s3_idx_reg;

    prac_sine_rom #(
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
        .TRIG_FRAC_BITS     (TRIG_FRAC_BITS)
    ) u_sine_rom (
        .clk       (clk),
        .en        (en4),
        .sin_addr  (s3_idx_reg),
        .cos_addr  (cos_addr),
        .sin_value (sin_value),
        .cos_value (cos_value)
    );

    always_comb
    begin
        sin_pos = TRIG_W'(sin_value);
        cos_pos = TRIG_W'(cos_value);
        case (s4_quad_reg)
            QUAD_FIRST:
            begin
                sn_next = sin_pos;
                cs_next = cos_pos;
            end
            QUAD_SECOND:
            begin
                sn_next = cos_pos;
                cs_next = -sin_pos;
            end
            QUAD_THIRD:
            begin
                sn_next = -sin_pos;
                cs_next = -cos_pos;
            end
            default:
            begin
                sn_next = -cos_pos;
                cs_next = sin_pos;
            end
        endcase
        s5_xc_next = PROD_W'(s4_dx_reg) * PROD_W'(cs_next);
        s5_ys_next = PROD_W'(s4_dy_reg) * PROD_W'(sn_next);
        s5_xs_next = PROD_W'(s4_dx_reg) * PROD_W'(sn_next);
        s5_yc_next = PROD_W'(s4_dy_reg) * PROD_W'(cs_next);
    end

    // floor((sum + half) / 2^F) is the top bits of the rounded sum
    always_comb
    begin
        sum_x  = SUM_W'(s5_xc_reg) - SUM_W'(s5_ys_reg);
        sum_y  = SUM_W'(s5_xs_reg) + SUM_W'(s5_yc_reg);
        rsum_x = sum_x + ROUND_HALF;
        rsum_y = sum_y + ROUND_HALF;
    end

    always_comb
    begin
        tot_x = TOT_W'(s6_cx_reg) + TOT_W'(s6_rx_reg);
        tot_y = TOT_W'(s6_cy_reg) + TOT_W'(s6_ry_reg);

        if ((&tot_x[TOT_W-1:COORD_W-1]) || !(|tot_x[TOT_W-1:COORD_W-1]))
            s7_x_next = tot_x[COORD_W-1:0];
        else
            s7_x_next = tot_x[TOT_W-1] ? COORD_MIN : COORD_MAX;

        if ((&tot_y[TOT_W-1:COORD_W-1]) || !(|tot_y[TOT_W-1:COORD_W-1]))
            s7_y_next = tot_y[COORD_W-1:0];
        else
            s7_y_next = tot_y[TOT_W-1] ? COORD_MIN : COORD_MAX;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_quad_reg   <= s1_quad_next;
            s1_offset_reg <= s1_offset_next;
            s1_dx_reg     <= s1_dx_next;
            s1_dy_reg     <= s1_dy_next;
            s1_cx_reg     <= pivot_x;
            s1_cy_reg     <= pivot_y;
        end
        if (en2)
        begin
            s2_quad_reg   <= s1_quad_reg;
            s2_scaled_reg <= s2_scaled_next[M_W-1:QUARTER_SHIFT];
            s2_dx_reg     <= s1_dx_reg;
            s2_dy_reg     <= s1_dy_reg;
            s2_cx_reg     <= s1_cx_reg;
            s2_cy_reg     <= s1_cy_reg;
        end
        if (en3)
        begin
            s3_quad_reg <= s2_quad_reg;
            s3_idx_reg  <= s3_prod_next[RECIP_SH +: IDX_W];
            s3_dx_reg   <= s2_dx_reg;
            s3_dy_reg   <= s2_dy_reg;
            s3_cx_reg   <= s2_cx_reg;
            s3_cy_reg   <= s2_cy_reg;
        end
        if (en4)
        begin
            s4_quad_reg <= s3_quad_reg;
            s4_dx_reg   <= s3_dx_reg;
            s4_dy_reg   <= s3_dy_reg;
            s4_cx_reg   <= s3_cx_reg;
            s4_cy_reg   <= s3_cy_reg;
        end
        if (en5)
        begin
            s5_xc_reg <= s5_xc_next;
            s5_ys_reg <= s5_ys_next;
            s5_xs_reg <= s5_xs_next;
            s5_yc_reg <= s5_yc_next;
            s5_cx_reg <= s4_cx_reg;
            s5_cy_reg <= s4_cy_reg;
        end
        if (en6)
        begin
            s6_rx_reg <= rsum_x[SUM_W-1:F];
            s6_ry_reg <= rsum_y[SUM_W-1:F];
            s6_cx_reg <= s5_cx_reg;
            s6_cy_reg <= s5_cy_reg;
        end
        if (en7)
        begin
            s7_x_reg <= s7_x_next;
            s7_y_reg <= s7_y_next;
        end
    end

    assign result_valid = s7_valid_reg;
    assign rotated_x    = s7_x_reg;
    assign rotated_y    = s7_y_reg;

endmodule

FILE: rtl/prac_sine_rom.sv
module prac_sine_rom
    import prac_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = DEF_SINE_TABLE_ENTRIES,
    parameter int TRIG_FRAC_BITS     = DEF_TRIG_FRAC_BITS,
    localparam int IDX_W             = $clog2(SINE_TABLE_ENTRIES + 1)
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [IDX_W-1:0]        sin_addr,
    input  logic [IDX_W-1:0]        cos_addr,
    output logic [TRIG_FRAC_BITS:0] sin_value,
    output logic [TRIG_FRAC_BITS:0] cos_value
);

    localparam logic [63:0] ONE_Q = 64'd1 << TRIG_FRAC_BITS;

    logic [TRIG_FRAC_BITS:0] rom_table [SINE_TABLE_ENTRIES+1];
    logic [TRIG_FRAC_BITS:0] sin_value_reg;
    logic [TRIG_FRAC_BITS:0] cos_value_reg;

    // quarter wave, entry k = sin(k * 90deg / entries), unsigned q1.F
    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++)
    begin : g_entry
        localparam logic [63:0] THETA = (HALF_PI_Q31 * 64'(k) + 64'(SINE_TABLE_ENTRIES / 2))
                                        / 64'(SINE_TABLE_ENTRIES);
        localparam logic [63:0] SERIES  = sine_q31(THETA);
        localparam logic [63:0] ROUNDED = (SERIES + (64'd1 << (30 - TRIG_FRAC_BITS)))
                                          >> (31 - TRIG_FRAC_BITS);
        localparam logic [63:0] ENTRY   = (ROUNDED > ONE_Q) ? ONE_Q : ROUNDED;
        assign rom_table[k] = ENTRY[TRIG_FRAC_BITS:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_value_reg <= rom_table[sin_addr];
            cos_value_reg <= rom_table[cos_addr];
        end
    end

    assign sin_value = sin_value_reg;
    assign cos_value = cos_value_reg;

endmodule
